### hw/rtl/sab_pkg.sv
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types, tables and helper functions for the 16-bit simplified AES
// cipher: nibble s-boxes, GF(16) constant multiplies and key expansion.
// ----------------------------------------------------------------------------
package sab_pkg;

   localparam logic [15:0] KEY_RESET = 16'h4AF5;
   localparam logic [7:0]  RCON_A    = 8'h80;
   localparam logic [7:0]  RCON_B    = 8'h30;
   // low nibble of x^4+x+1, folded in when x^4 appears
   localparam logic [3:0]  GF_FOLD   = 4'h3;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam logic [3:0] SBOX_FWD [16] = '{
      4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
      4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7};
   localparam logic [3:0] SBOX_INV [16] = '{
      4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
      4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE};

   // three expanded round keys
   typedef struct packed {
      logic [15:0] k1;
      logic [15:0] k2;
      logic [15:0] k3;
   } rkeys_type;

   // multiply by x in GF(16)
   function automatic logic [3:0] gf_x2(input logic [3:0] a);
      return {a[2:0], 1'b0} ^ (a[3] ? GF_FOLD : 4'h0);
   endfunction

   function automatic logic [3:0] gf_x4(input logic [3:0] a);
      return gf_x2(gf_x2(a));
   endfunction

   function automatic logic [3:0] gf_x9(input logic [3:0] a);
      return gf_x2(gf_x4(a)) ^ a;
   endfunction

   // nibble substitution over a 16-bit word
   function automatic logic [15:0] sub_fwd16(input logic [15:0] v);
      return {SBOX_FWD[v[15:12]], SBOX_FWD[v[11:8]], SBOX_FWD[v[7:4]], SBOX_FWD[v[3:0]]};
   endfunction

   function automatic logic [15:0] sub_inv16(input logic [15:0] v);
      return {SBOX_INV[v[15:12]], SBOX_INV[v[11:8]], SBOX_INV[v[7:4]], SBOX_INV[v[3:0]]};
   endfunction

   // swap nibbles 1 and 3
   function automatic logic [15:0] swap13(input logic [15:0] v);
      return {v[15:12], v[3:0], v[7:4], v[11:8]};
   endfunction

   // one half of the key schedule: prev ^ rcon ^ SubNib(RotNib(w))
   function automatic logic [7:0] expand_half(input logic [7:0] w,
                                              input logic [7:0] prev,
                                              input logic [7:0] rcon);
      return prev ^ rcon ^ {SBOX_FWD[w[3:0]], SBOX_FWD[w[7:4]]};
   endfunction

   function automatic rkeys_type expand_key(input logic [15:0] key);
      logic [7:0] w2;
      logic [7:0] w3;
      logic [7:0] w4;
      logic [7:0] w5;
      rkeys_type  rk;
      w2 = expand_half(key[7:0], key[15:8], RCON_A);
      w3 = w2 ^ key[7:0];
      w4 = expand_half(w3, w2, RCON_B);
      w5 = w4 ^ w3;
      rk.k1 = key;
      rk.k2 = {w2, w3};
      rk.k3 = {w4, w5};
      return rk;
   endfunction

endpackage

### hw/rtl/s_aes_block_cipher_core.sv
// stages: an accepted item goes to the input register, then to the result register
// throughput: one item per cycle while the result side does not stall; the whole cipher sits between the two registers
// a key write is used by every item that leaves the input stage after the write cycle, also one already waiting there
// reset (synchronous, active high) empties both stages and loads key 16'h4AF5
// ----------------------------------------------------------------------------
// s_aes_block_cipher_core
// Simplified AES on 16-bit blocks, encrypt or decrypt per item, with a
// two-stage stream pipeline and a write-only key register.
// ----------------------------------------------------------------------------
module s_aes_block_cipher_core
   import sab_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // key register
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] data_block
   input  logic        req_tuser,   // [0] operation
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] result_block
);

   rkeys_type   rkeys;
   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic        s1_op_ff;
   logic [15:0] s1_data_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_data_ff;
   logic [15:0] result_block;
   logic        out_adv;
   logic        s1_move;
   logic        req_take;

   sab_keyexp u_keyexp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rkeys     (rkeys)
   );

   sab_datapath u_datapath (
      .operation    (s1_op_ff),
      .data_block   (s1_data_ff),
      .rkeys        (rkeys),
      .result_block (result_block)
   );

   // pipeline flow control
   assign out_adv    = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_adv;
   assign req_tready = !s1_valid_ff || out_adv;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_adv) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_tuser;
         s1_data_ff <= req_tdata;
      end
      if (s1_move) begin
         rsp_data_ff <= result_block;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // an accepted item always lands in the input stage
   a_take_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted item missing from input stage");

   // input stage moves to the result register when it can
   a_s1_to_rsp : assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("result lost between stages");

   // back-pressure only when both stages hold items and the sink stalls
   a_ready_low_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled while pipeline has room");

   // a stalled input stage keeps its item
   a_s1_hold : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_adv) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("input stage item dropped under stall");
`endif

endmodule

### hw/rtl/sab_keyexp.sv
// ----------------------------------------------------------------------------
// sab_keyexp
// Holds the expanded round keys. The schedule is worked out from the write
// data when the key register is written, so the datapath sees ready keys.
// ----------------------------------------------------------------------------
module sab_keyexp
   import sab_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output rkeys_type   rkeys
);

   rkeys_type rkeys_ff;
   rkeys_type rkeys_in;

   // expand on write, hold otherwise
   always_comb begin
      rkeys_in = rkeys_ff;
      if (csr_we) begin
         rkeys_in = expand_key(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rkeys_ff <= expand_key(KEY_RESET);
      end else begin
         rkeys_ff <= rkeys_in;
      end
   end

   assign rkeys = rkeys_ff;

endmodule

### hw/rtl/sab_datapath.sv
// ----------------------------------------------------------------------------
// sab_datapath
// Both cipher directions for one block: two rounds of key add, nibble
// substitution and shift, one column mix, selected by the operation bit.
// ----------------------------------------------------------------------------
module sab_datapath
   import sab_pkg::*;
(
   input  logic        operation,
   input  logic [15:0] data_block,
   input  rkeys_type   rkeys,
   output logic [15:0] result_block
);

   logic [15:0] enc_r1;
   logic [15:0] enc_mix;
   logic [15:0] enc_out;
   logic [15:0] dec_r1;
   logic [15:0] dec_mix;
   logic [15:0] dec_out;

   // encrypt: add k1, sub, shift, mix {1,4},{4,1}, add k2, sub, shift, add k3
   always_comb begin
      enc_r1  = swap13(sub_fwd16(data_block ^ rkeys.k1));
      enc_mix = {enc_r1[15:12] ^ gf_x4(enc_r1[11:8]),
                 gf_x4(enc_r1[15:12]) ^ enc_r1[11:8],
                 enc_r1[7:4] ^ gf_x4(enc_r1[3:0]),
                 gf_x4(enc_r1[7:4]) ^ enc_r1[3:0]};
      enc_out = swap13(sub_fwd16(enc_mix ^ rkeys.k2)) ^ rkeys.k3;
   end

   // decrypt: add k3, shift, inv sub, add k2, mix {9,2},{2,9}, shift, inv sub, add k1
   always_comb begin
      dec_r1  = sub_inv16(swap13(data_block ^ rkeys.k3)) ^ rkeys.k2;
      dec_mix = {gf_x9(dec_r1[15:12]) ^ gf_x2(dec_r1[11:8]),
                 gf_x2(dec_r1[15:12]) ^ gf_x9(dec_r1[11:8]),
                 gf_x9(dec_r1[7:4]) ^ gf_x2(dec_r1[3:0]),
                 gf_x2(dec_r1[7:4]) ^ gf_x9(dec_r1[3:0])};
      dec_out = sub_inv16(swap13(dec_mix)) ^ rkeys.k1;
   end

   // direction select
   always_comb begin
      unique case (operation)
         OP_ENCRYPT: result_block = enc_out;
         OP_DECRYPT: result_block = dec_out;
         default:    result_block = enc_out;
      endcase
   end

endmodule

### tb/tb_s_aes_block_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_s_aes_block_cipher_core
// Streams blocks through the 16-bit simplified AES core under several keys:
// edge cases first, then a known vector, random blocks and
// encrypt/decrypt round trips. A scoreboard predicts every result and
// checks them in order while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

// in-order scoreboard with its own model of the cipher
class cipher_scoreboard;

   bit [3:0]  fwd_box [16] = '{
      4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
      4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7};
   bit [3:0]  inv_box [16] = '{
      4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
      4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE};
   bit [15:0] round_key1;
   bit [15:0] round_key2;
   bit [15:0] round_key3;
   bit [15:0] expected_blocks [$];
   int unsigned mismatch_count;

   function new(bit [15:0] key);
      mismatch_count = 0;
      set_key(key);
   endfunction

   // carry-less multiply reduced by x^4+x+1
   function bit [3:0] gf_mult(bit [3:0] a, bit [3:0] b);
      bit [4:0] acc;
      bit [3:0] prod;
      acc  = {1'b0, a};
      prod = 4'h0;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) prod ^= acc[3:0];
         acc = acc << 1;
         if (acc[4]) acc ^= 5'h13;
      end
      return prod;
   endfunction

   function bit [15:0] sub_nibbles(bit [15:0] v, bit inverse);
      bit [15:0] r;
      for (int i = 0; i < 4; i++)
         r[4*i +: 4] = inverse ? inv_box[v[4*i +: 4]] : fwd_box[v[4*i +: 4]];
      return r;
   endfunction

   function bit [15:0] swap_nibbles(bit [15:0] v);
      return {v[15:12], v[3:0], v[7:4], v[11:8]};
   endfunction

   // column matrix {d, o}, {o, d} over both columns
   function bit [15:0] mix_columns(bit [15:0] v, bit [3:0] d, bit [3:0] o);
      return {gf_mult(d, v[15:12]) ^ gf_mult(o, v[11:8]),
              gf_mult(o, v[15:12]) ^ gf_mult(d, v[11:8]),
              gf_mult(d, v[7:4])   ^ gf_mult(o, v[3:0]),
              gf_mult(o, v[7:4])   ^ gf_mult(d, v[3:0])};
   endfunction

   function bit [7:0] next_half(bit [7:0] w, bit [7:0] prev, bit [7:0] rcon);
      return prev ^ rcon ^ {fwd_box[w[3:0]], fwd_box[w[7:4]]};
   endfunction

   // key schedule
   function void set_key(bit [15:0] key);
      bit [7:0] w2;
      bit [7:0] w3;
      bit [7:0] w4;
      w2 = next_half(key[7:0], key[15:8], 8'h80);
      w3 = w2 ^ key[7:0];
      w4 = next_half(w3, w2, 8'h30);
      round_key1 = key;
      round_key2 = {w2, w3};
      round_key3 = {w4, w4 ^ w3};
   endfunction

   function bit [15:0] cipher_block(bit op, bit [15:0] blk);
      bit [15:0] s;
      if (op == sab_pkg::OP_ENCRYPT) begin
         s = swap_nibbles(sub_nibbles(blk ^ round_key1, 1'b0));
         s = mix_columns(s, 4'h1, 4'h4) ^ round_key2;
         s = swap_nibbles(sub_nibbles(s, 1'b0)) ^ round_key3;
      end else begin
         s = sub_nibbles(swap_nibbles(blk ^ round_key3), 1'b1) ^ round_key2;
         s = mix_columns(s, 4'h9, 4'h2);
         s = sub_nibbles(swap_nibbles(s), 1'b1) ^ round_key1;
      end
      return s;
   endfunction

   // append the prediction at the tail of the queue
   function void note_input(bit op, bit [15:0] blk);
      expected_blocks = {expected_blocks, cipher_block(op, blk)};
   endfunction

   function void check_result(bit [15:0] actual);
      bit [15:0] want;
      if (expected_blocks.size() == 0) begin
         $error("result_block: unexpected item, actual %h", actual);
         mismatch_count++;
      end else begin
         want = expected_blocks.pop_front();
         if (actual !== want) begin
            $error("result_block mismatch: expected %h, actual %h", want, actual);
            mismatch_count++;
         end
      end
   endfunction

   function int unsigned pending();
      return expected_blocks.size();
   endfunction

endclass

module tb_s_aes_block_cipher_core;
   import sab_pkg::*;

   localparam logic [15:0] POWER_ON_KEY = 16'h4AF5;
   localparam int unsigned LIMIT_CYCLES = 300000;
   localparam int unsigned PHASE_ITEMS  = 180;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [15:0] csr_wdata  = 16'h0000;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'h0000;   // [15:0] data_block
   logic        req_tuser  = OP_ENCRYPT; // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;               // [15:0] result_block

   cipher_scoreboard sb = new(POWER_ON_KEY);

   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;
   int unsigned stall_left  = 0;
   int unsigned stall_mode  = 0;
   int unsigned stall_tick  = 0;

   s_aes_block_cipher_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // accepted items on both sides go to the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_input(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // receiver stalls in randomly chosen modes
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 4);
         stall_left = $urandom_range(10, 80);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         0, 1: begin
            rsp_tready <= 1'b1;
         end
         2: begin
            rsp_tready <= ($urandom_range(0, 1) == 1);
         end
         3: begin
            rsp_tready <= (stall_tick % 4 == 0);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 5) == 0);
         end
      endcase
   end

   // one item, held until accepted; random gaps between bursts
   task automatic send_item(input logic op, input logic [15:0] blk);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= blk;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end else begin
         burst_left--;
      end
   endtask

   // stop sending and let every expected result come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_key(input logic [15:0] key);
      csr_we    <= 1'b1;
      csr_wdata <= key;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_key(key);
   endtask

   // random blocks mixed with encrypt-then-decrypt round trips
   task automatic run_random_phase(input int unsigned count);
      int unsigned sent;
      logic [15:0] plain;
      sent = 0;
      while (sent < count) begin
         plain = 16'($urandom_range(0, 16'hFFFF));
         if ($urandom_range(0, 9) < 4) begin
            send_item(OP_ENCRYPT, plain);
            send_item(OP_DECRYPT, sb.cipher_block(OP_ENCRYPT, plain));
            sent += 2;
         end else begin
            send_item(1'($urandom_range(0, 1)), plain);
            sent++;
         end
      end
   endtask

   // watchdog
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // power-on key: extremes, single bits, alternating patterns and a round trip, then random blocks
      send_item(OP_ENCRYPT, 16'h0000);
      send_item(OP_ENCRYPT, 16'hFFFF);
      send_item(OP_DECRYPT, 16'h0000);
      send_item(OP_DECRYPT, 16'hFFFF);
      send_item(OP_ENCRYPT, 16'h8000);
      send_item(OP_DECRYPT, 16'h0001);
      send_item(OP_ENCRYPT, 16'hA5A5);
      send_item(OP_DECRYPT, 16'h5A5A);
      send_item(OP_ENCRYPT, 16'h1234);
      send_item(OP_DECRYPT, sb.cipher_block(OP_ENCRYPT, 16'h1234));
      run_random_phase(PHASE_ITEMS);
      drain_results();

      // textbook vector, then all-zero and all-one keys
      write_key(16'hA73B);
      send_item(OP_ENCRYPT, 16'h6F6B);
      send_item(OP_DECRYPT, 16'h0738);
      drain_results();
      write_key(16'h0000);
      send_item(OP_ENCRYPT, 16'h0000);
      send_item(OP_DECRYPT, 16'hFFFF);
      run_random_phase(PHASE_ITEMS);
      drain_results();
      write_key(16'hFFFF);
      send_item(OP_ENCRYPT, 16'hFFFF);
      send_item(OP_DECRYPT, 16'h0000);
      run_random_phase(PHASE_ITEMS);
      drain_results();

      // random keys
      repeat (5) begin
         write_key(16'($urandom_range(0, 16'hFFFF)));
         run_random_phase(PHASE_ITEMS);
         drain_results();
      end

      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
